@@ design/fpalu_pkg.sv @@
// ============================================================================
// fpalu_pkg - shared codes for the Q24.8 fixed-point ALU
// Operation codes, port widths and flag positions used by the ALU.
// ============================================================================
package fpalu_pkg;

    localparam int DATA_W = 32;
    localparam int KIND_W = 4;
    localparam int FLAG_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 4'd0,
        KIND_SUB    = 4'd1,
        KIND_MUL    = 4'd2,
        KIND_DIV    = 4'd3,
        KIND_MIN    = 4'd4,
        KIND_MAX    = 4'd5,
        KIND_INC    = 4'd6,
        KIND_DEC    = 4'd7,
        KIND_TO_INT = 4'd8
    } kind_t;

    // Bit positions in the result tuser
    localparam int FLAG_GT  = 0;
    localparam int FLAG_LT  = 1;
    localparam int FLAG_EQ  = 2;
    localparam int FLAG_OV  = 3;
    localparam int FLAG_DBZ = 4;

endpackage

@@ design/fixed_point_q24_8_alu.sv @@
// ============================================================================
// fixed_point_q24_8_alu - pipelined fixed-point ALU
// Every result passes through the restoring divider, which retires one
// quotient bit per pipeline stage.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output. Reset clears the valid bits only.
// ============================================================================
module fixed_point_q24_8_alu #(
    parameter int FRACTION_BITS = 8,
    parameter int RAW_WIDTH     = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] operand_a, [63:32] operand_b
    input  logic [2*fpalu_pkg::DATA_W-1:0]      s_axis_tdata,
    // [3:0] kind
    input  logic [fpalu_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] result_raw
    output logic [fpalu_pkg::DATA_W-1:0]        m_axis_tdata,
    // [0] a_greater, [1] a_less, [2] a_equal, [3] overflowed, [4] divide_by_zero
    output logic [fpalu_pkg::FLAG_W-1:0]        m_axis_tuser
);

    localparam int W  = RAW_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int DW = W + F;
    localparam int EW = 2 * W + 1;
    localparam logic [2*W-1:0] MUL_BIAS = (2*W)'((64'd1 << F) - 64'd1);

    typedef struct packed {
        logic [fpalu_pkg::KIND_W-1:0] kind;
        logic signed [W-1:0]          a;
        logic signed [W-1:0]          b;
        logic                         gt;
        logic                         lt;
        logic                         eq;
        logic signed [2*W-1:0]        prod;
        logic                         qneg;
        logic                         dbz;
        logic [W:0]                   rem;
        logic [DW-1:0]                dvd;
        logic [W-1:0]                 dvs;
        logic [DW-1:0]                quo;
    } dv_t;

    typedef struct packed {
        logic                         gt;
        logic                         lt;
        logic                         eq;
        logic                         dbz;
        logic                         cov;
        logic signed [EW-1:0]         ex;
    } fin_t;

    logic adv;

    // stage 0: operands and compare flags
    logic                         s0_vld_reg;
    logic [fpalu_pkg::KIND_W-1:0] s0_kind_reg;
    logic signed [W-1:0]          s0_a_reg;
    logic signed [W-1:0]          s0_b_reg;
    logic                         s0_gt_reg;
    logic                         s0_lt_reg;
    logic                         s0_eq_reg;
    logic signed [W-1:0]          in_a;
    logic signed [W-1:0]          in_b;

    // divider stages; index 0 is loaded from stage 0
    dv_t        dv_reg  [DW+1];
    dv_t        dv_next [DW+1];
    logic [DW:0] dv_vld_reg;

    fin_t f1_reg;
    fin_t f1_next;
    logic f1_vld_reg;

    logic                        out_vld_reg;
    logic [fpalu_pkg::DATA_W-1:0] out_data_reg;
    logic [fpalu_pkg::FLAG_W-1:0] out_flag_reg;
    logic [fpalu_pkg::DATA_W-1:0] out_data_next;
    logic [fpalu_pkg::FLAG_W-1:0] out_flag_next;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

    assign in_a = s_axis_tdata[W-1:0];
    assign in_b = s_axis_tdata[fpalu_pkg::DATA_W +: W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            f1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg  <= s_axis_tvalid;
            dv_vld_reg  <= {dv_vld_reg[DW-1:0], s0_vld_reg};
            f1_vld_reg  <= dv_vld_reg[DW];
            out_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_kind_reg <= s_axis_tuser;
            s0_a_reg    <= in_a;
            s0_b_reg    <= in_b;
            s0_gt_reg   <= in_a > in_b;
            s0_lt_reg   <= in_a < in_b;
            s0_eq_reg   <= in_a == in_b;
        end
    end

    // stage 1: product, magnitudes, divider set-up
    always_comb
    begin
        logic [W-1:0] abs_a;
        logic [W-1:0] abs_b;
        abs_a = s0_a_reg[W-1] ? W'(-s0_a_reg) : W'(s0_a_reg);
        abs_b = s0_b_reg[W-1] ? W'(-s0_b_reg) : W'(s0_b_reg);
        dv_next[0].kind = s0_kind_reg;
        dv_next[0].a    = s0_a_reg;
        dv_next[0].b    = s0_b_reg;
        dv_next[0].gt   = s0_gt_reg;
        dv_next[0].lt   = s0_lt_reg;
        dv_next[0].eq   = s0_eq_reg;
        dv_next[0].prod = s0_a_reg * s0_b_reg;
        dv_next[0].qneg = s0_a_reg[W-1] ^ s0_b_reg[W-1];
        dv_next[0].dbz  = (s0_b_reg == '0);
        dv_next[0].rem  = '0;
        dv_next[0].dvd  = DW'(abs_a) << F;
        dv_next[0].dvs  = abs_b;
        dv_next[0].quo  = '0;
    end

    // one quotient bit per stage
    for (genvar i = 0; i < DW; i++)
    begin : g_div
        always_comb
        begin
            logic [W:0] rsh;
            logic [W:0] dif;
            rsh = {dv_reg[i].rem[W-1:0], dv_reg[i].dvd[DW-1]};
            dif = rsh - {1'b0, dv_reg[i].dvs};
            dv_next[i+1]     = dv_reg[i];
            dv_next[i+1].rem = dif[W] ? rsh : dif;
            dv_next[i+1].quo = {dv_reg[i].quo[DW-2:0], ~dif[W]};
            dv_next[i+1].dvd = dv_reg[i].dvd << 1;
        end
    end

    for (genvar i = 0; i <= DW; i++)
    begin : g_dv_reg
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[i] <= dv_next[i];
            end
        end
    end

    // final stage 1: per-operation exact value
    always_comb
    begin
        logic signed [W:0]     ax;
        logic signed [W:0]     bx;
        logic signed [2*W-1:0] mq;
        logic signed [DW:0]    qs;
        dv_t                   d;
        d  = dv_reg[DW];
        ax = (W+1)'(d.a);
        bx = (W+1)'(d.b);
        // bias negative products so the shift truncates toward zero
        mq = (d.prod + (d.prod[2*W-1] ? signed'(MUL_BIAS) : signed'((2*W)'(0)))) >>> F;
        qs = d.qneg ? -signed'({1'b0, d.quo}) : signed'({1'b0, d.quo});
        f1_next.gt  = d.gt;
        f1_next.lt  = d.lt;
        f1_next.eq  = d.eq;
        f1_next.dbz = 1'b0;
        f1_next.cov = 1'b1;
        f1_next.ex  = '0;
        unique case (fpalu_pkg::kind_t'(d.kind))
            fpalu_pkg::KIND_ADD: f1_next.ex = EW'(ax + bx);
            fpalu_pkg::KIND_SUB: f1_next.ex = EW'(ax - bx);
            fpalu_pkg::KIND_MUL: f1_next.ex = EW'(mq);
            fpalu_pkg::KIND_DIV:
            begin
                if (d.dbz)
                begin
                    f1_next.dbz = 1'b1;
                    f1_next.cov = 1'b0;
                end
                else
                begin
                    f1_next.ex = EW'(qs);
                end
            end
            fpalu_pkg::KIND_MIN:
            begin
                f1_next.ex  = d.gt ? EW'(d.b) : EW'(d.a);
                f1_next.cov = 1'b0;
            end
            fpalu_pkg::KIND_MAX:
            begin
                f1_next.ex  = (d.gt || d.eq) ? EW'(d.a) : EW'(d.b);
                f1_next.cov = 1'b0;
            end
            fpalu_pkg::KIND_INC: f1_next.ex = EW'(ax + (W+1)'(1));
            fpalu_pkg::KIND_DEC: f1_next.ex = EW'(ax - (W+1)'(1));
            fpalu_pkg::KIND_TO_INT:
            begin
                f1_next.ex  = EW'(d.a >>> F);
                f1_next.cov = 1'b0;
            end
            default:
            begin
                f1_next.cov = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= f1_next;
        end
    end

    // final stage 2: wrap, range check, pack
    always_comb
    begin
        logic [EW-W:0]       hi;
        logic signed [W-1:0] res;
        hi  = f1_reg.ex[EW-1:W-1];
        res = f1_reg.ex[W-1:0];
        out_data_next                     = fpalu_pkg::DATA_W'(res);
        out_flag_next[fpalu_pkg::FLAG_GT]  = f1_reg.gt;
        out_flag_next[fpalu_pkg::FLAG_LT]  = f1_reg.lt;
        out_flag_next[fpalu_pkg::FLAG_EQ]  = f1_reg.eq;
        out_flag_next[fpalu_pkg::FLAG_OV]  = f1_reg.cov && !((&hi) || !(|hi));
        out_flag_next[fpalu_pkg::FLAG_DBZ] = f1_reg.dbz;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_flag_reg <= out_flag_next;
        end
    end

    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_flag_reg[fpalu_pkg::FLAG_DBZ]
        |-> out_data_reg == '0 && !out_flag_reg[fpalu_pkg::FLAG_OV])
        else $error("divide by zero result not cleared");

    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> $onehot(out_flag_reg[fpalu_pkg::FLAG_EQ:fpalu_pkg::FLAG_GT]))
        else $error("compare flags not exclusive");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DW] && dv_reg[DW].dvs != '0
        |-> dv_reg[DW].rem < {1'b0, dv_reg[DW].dvs})
        else $error("divider remainder out of range");

    a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[DW] && adv |=> f1_vld_reg)
        else $error("item lost leaving divider");

endmodule
